// ===== rtl/mesh_cell_warp_coordinate_generator_top_assert.svh =====
// Assertion macros for the mesh cell warp coordinate generator.
// Used by mesh_cell_warp_coordinate_generator_top; depends on nothing else.
`ifndef MESH_CELL_WARP_COORDINATE_GENERATOR_TOP_ASSERT_SVH
`define MESH_CELL_WARP_COORDINATE_GENERATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MCWCG_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define MCWCG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/mcwcg_pkg.sv =====
// Shared widths, constants and helpers of the mesh cell warp coordinate generator.
// Used by mcwcg_div and the top level; depends on nothing.
package mcwcg_pkg;
   localparam int CORNER_W      = 24;
   localparam int COORD_FRAC_BITS = 8;
   localparam int SPAN_W        = 8;
   localparam int MAX_CELL_SPAN = 255;
   localparam int FRAME_DIM_MAX = 8192;
   localparam int DIM_W         = 14;
   localparam int QUO_W         = 13;
   localparam int DEN_W         = 24;
   localparam int REM_W         = 38;
   localparam int PROD_W        = 33;
   localparam int SUM_W         = 34;
   localparam int MUL_W         = 43;
   localparam int NUM_W         = 44;
   localparam int FRONT_STAGES  = 5;
   localparam int PIPE_DEPTH    = FRONT_STAGES + QUO_W;
   localparam int REQ_DATA_W    = 224;
   localparam int RSP_DATA_W    = 32;

   typedef enum logic {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      if (v > DIM_W'(FRAME_DIM_MAX))
         return DIM_W'(FRAME_DIM_MAX);
      return v;
   endfunction
endpackage

// ===== rtl/mcwcg_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, stalls with ce.
// Depends on mcwcg_pkg.
module mcwcg_div
   import mcwcg_pkg::*;
(
   input  logic             clock,
   input  logic             ce,
   input  logic [REM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [QUO_W-1:0] quo
);
   logic [REM_W-1:0] rem_ff [QUO_W];
   logic [DEN_W-1:0] den_ff [QUO_W];
   logic [QUO_W-1:0] q_ff   [QUO_W];

   for (genvar i = 0; i < QUO_W; i++) begin : g_stage
      localparam int BIT = QUO_W - 1 - i;
      logic [REM_W-1:0] rem_src;
      logic [DEN_W-1:0] den_src;
      logic [QUO_W-1:0] q_src;
      logic [REM_W:0]   trial;
      logic [REM_W-1:0] rem_in;
      logic [QUO_W-1:0] q_in;

      if (i == 0) begin : g_first
         assign rem_src = num;
         assign den_src = den;
         assign q_src   = '0;
      end else begin : g_next
         assign rem_src = rem_ff[i-1];
         assign den_src = den_ff[i-1];
         assign q_src   = q_ff[i-1];
      end

      always_comb begin
         trial = {1'b0, rem_src} - ((REM_W+1)'(den_src) << BIT);
         if (!trial[REM_W]) begin
            rem_in = trial[REM_W-1:0];
            q_in   = {q_src[QUO_W-2:0], 1'b1};
         end else begin
            rem_in = rem_src;
            q_in   = {q_src[QUO_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            rem_ff[i] <= rem_in;
            den_ff[i] <= den_src;
            q_ff[i]   <= q_in;
         end
      end
   end

   assign quo = q_ff[QUO_W-1];
endmodule

// ===== rtl/mesh_cell_warp_coordinate_generator_top.sv =====
// Top level of the mesh cell warp coordinate generator: weights, bilinear blend,
// bounds check and floor division. Depends on mcwcg_pkg, mcwcg_div and the assert header.
//
//   channel  | dir | handshake              | payload
//   req_     | in  | req_tvalid/req_tready  | req_tdata: four corners, offsets, spans
//   rsp_     | out | rsp_tvalid/rsp_tready  | rsp_tdata: source_x/y, in_frame, skipped
//   csr_     | in  | csr_we                 | csr_index, csr_wdata
//
// One item per cycle unless stalled; the pipeline is 5 blend stages plus one per
// quotient bit of the 13-stage divider. The whole pipeline advances together and
// holds when the output register is full and not taken. Synchronous reset clears
// the valid bits and loads the frame registers with 1920 x 1080.
module mesh_cell_warp_coordinate_generator_top
   import mcwcg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // corner_a_x, corner_a_y, corner_b_x, corner_b_y, corner_c_x, corner_c_y,
   // corner_d_x, corner_d_y, offset_x, offset_y, span_x, span_y
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // source_x, source_y, in_frame, cell_skipped, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [DIM_W-1:0]      csr_wdata
);
   logic [DIM_W-1:0] frame_w_ff, frame_h_ff;
   logic [DIM_W-1:0] w_lim, h_lim;
   logic             ce;
   logic             v_ff [PIPE_DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_w_ff <= DIM_W'(1920);
         frame_h_ff <= DIM_W'(1080);
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:  frame_w_ff <= csr_wdata;
            CSR_FRAME_HEIGHT: frame_h_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign w_lim = clamp_dim(frame_w_ff);
   assign h_lim = clamp_dim(frame_h_ff);

   assign ce         = !v_ff[PIPE_DEPTH-1] || rsp_tready;
   assign req_tready = ce;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIPE_DEPTH; i++) v_ff[i] <= 1'b0;
      end else if (ce) begin
         v_ff[0] <= req_tvalid;
         for (int i = 1; i < PIPE_DEPTH; i++) v_ff[i] <= v_ff[i-1];
      end
   end

   // ---- stage 0: unpack, clamp spans and offsets, skip test
   logic signed [CORNER_W-1:0] cx_in [4];
   logic signed [CORNER_W-1:0] cy_in [4];
   logic [SPAN_W-1:0] ox, oy, sx_raw, sy_raw, sx, sy, ox_c, oy_c;
   logic [SPAN_W-1:0] sx_in, sy_in, lx_in, ly_in;
   logic [3:0]        corner_out;
   logic [CORNER_W-1:0] w_fix, h_fix;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         cx_in[k] = req_tdata[2*k*CORNER_W +: CORNER_W];
         cy_in[k] = req_tdata[(2*k+1)*CORNER_W +: CORNER_W];
      end
      ox     = req_tdata[8*CORNER_W +: SPAN_W];
      oy     = req_tdata[8*CORNER_W+SPAN_W +: SPAN_W];
      sx_raw = req_tdata[8*CORNER_W+2*SPAN_W +: SPAN_W];
      sy_raw = req_tdata[8*CORNER_W+3*SPAN_W +: SPAN_W];
      sx = (sx_raw > SPAN_W'(MAX_CELL_SPAN)) ? SPAN_W'(MAX_CELL_SPAN) : sx_raw;
      sy = (sy_raw > SPAN_W'(MAX_CELL_SPAN)) ? SPAN_W'(MAX_CELL_SPAN) : sy_raw;
      ox_c = (ox > sx) ? sx : ox;
      oy_c = (oy > sy) ? sy : oy;
      // zero span: weight zero, divide by one
      sx_in = (sx == '0) ? SPAN_W'(1) : sx;
      lx_in = (sx == '0) ? '0 : ox_c;
      sy_in = (sy == '0) ? SPAN_W'(1) : sy;
      ly_in = (sy == '0) ? '0 : oy_c;
      w_fix = CORNER_W'(w_lim) << COORD_FRAC_BITS;
      h_fix = CORNER_W'(h_lim) << COORD_FRAC_BITS;
      for (int k = 0; k < 4; k++) begin
         corner_out[k] = cx_in[k][CORNER_W-1] || (cx_in[k] >= $signed(w_fix)) ||
                         cy_in[k][CORNER_W-1] || (cy_in[k] >= $signed(h_fix));
      end
   end

   // ---- stage 1
   logic signed [CORNER_W-1:0] cx_s1_ff [4];
   logic signed [CORNER_W-1:0] cy_s1_ff [4];
   logic [SPAN_W-1:0] sx_s1_ff, sy_s1_ff, lx_s1_ff, ly_s1_ff;
   logic              skip_s1_ff;

   always_ff @(posedge clock) begin
      if (ce) begin
         cx_s1_ff   <= cx_in;
         cy_s1_ff   <= cy_in;
         sx_s1_ff   <= sx_in;
         sy_s1_ff   <= sy_in;
         lx_s1_ff   <= lx_in;
         ly_s1_ff   <= ly_in;
         skip_s1_ff <= &corner_out;
      end
   end

   // ---- stage 2: horizontal weight products
   logic signed [SPAN_W:0]   rx_s, lx_s;
   logic signed [PROD_W-1:0] px_s2_ff [4];
   logic signed [PROD_W-1:0] py_s2_ff [4];
   logic [SPAN_W-1:0]        ry_s2_ff, ly_s2_ff;
   logic [2*SPAN_W-1:0]      sxy_s2_ff;
   logic                     skip_s2_ff;

   assign rx_s = $signed({1'b0, sx_s1_ff - lx_s1_ff});
   assign lx_s = $signed({1'b0, lx_s1_ff});

   always_ff @(posedge clock) begin
      if (ce) begin
         for (int k = 0; k < 4; k++) begin
            px_s2_ff[k] <= ((k % 2) == 0) ? rx_s * cx_s1_ff[k] : lx_s * cx_s1_ff[k];
            py_s2_ff[k] <= ((k % 2) == 0) ? rx_s * cy_s1_ff[k] : lx_s * cy_s1_ff[k];
         end
         ry_s2_ff   <= sy_s1_ff - ly_s1_ff;
         ly_s2_ff   <= ly_s1_ff;
         sxy_s2_ff  <= sx_s1_ff * sy_s1_ff;
         skip_s2_ff <= skip_s1_ff;
      end
   end

   // ---- stage 3: row sums
   logic signed [SUM_W-1:0] abx_s3_ff, cdx_s3_ff, aby_s3_ff, cdy_s3_ff;
   logic [SPAN_W-1:0]       ry_s3_ff, ly_s3_ff;
   logic [DEN_W-1:0]        den_s3_ff;
   logic                    skip_s3_ff;

   always_ff @(posedge clock) begin
      if (ce) begin
         abx_s3_ff  <= SUM_W'(px_s2_ff[0]) + SUM_W'(px_s2_ff[1]);
         cdx_s3_ff  <= SUM_W'(px_s2_ff[2]) + SUM_W'(px_s2_ff[3]);
         aby_s3_ff  <= SUM_W'(py_s2_ff[0]) + SUM_W'(py_s2_ff[1]);
         cdy_s3_ff  <= SUM_W'(py_s2_ff[2]) + SUM_W'(py_s2_ff[3]);
         ry_s3_ff   <= ry_s2_ff;
         ly_s3_ff   <= ly_s2_ff;
         den_s3_ff  <= DEN_W'(sxy_s2_ff) << COORD_FRAC_BITS;
         skip_s3_ff <= skip_s2_ff;
      end
   end

   // ---- stage 4: vertical weight products, frame limits scaled by den
   logic signed [SPAN_W:0]  ry_s, ly_s;
   logic signed [MUL_W-1:0] mabx_s4_ff, mcdx_s4_ff, maby_s4_ff, mcdy_s4_ff;
   logic [REM_W-1:0]        wden_s4_ff, hden_s4_ff;
   logic [DEN_W-1:0]        den_s4_ff;
   logic                    skip_s4_ff;

   assign ry_s = $signed({1'b0, ry_s3_ff});
   assign ly_s = $signed({1'b0, ly_s3_ff});

   always_ff @(posedge clock) begin
      if (ce) begin
         mabx_s4_ff <= ry_s * abx_s3_ff;
         mcdx_s4_ff <= ly_s * cdx_s3_ff;
         maby_s4_ff <= ry_s * aby_s3_ff;
         mcdy_s4_ff <= ly_s * cdy_s3_ff;
         wden_s4_ff <= w_lim * den_s3_ff;
         hden_s4_ff <= h_lim * den_s3_ff;
         den_s4_ff  <= den_s3_ff;
         skip_s4_ff <= skip_s3_ff;
      end
   end

   // ---- stage 5: final sum and bounds check; zero the numerator when outside
   logic signed [NUM_W-1:0] nx, ny;
   logic                    pt_in;
   logic [REM_W-1:0]        nx_s5_ff, ny_s5_ff;
   logic [DEN_W-1:0]        den_s5_ff;
   logic                    in_s5_ff, skip_s5_ff;

   always_comb begin
      nx = NUM_W'(mabx_s4_ff) + NUM_W'(mcdx_s4_ff);
      ny = NUM_W'(maby_s4_ff) + NUM_W'(mcdy_s4_ff);
      pt_in = !skip_s4_ff && !nx[NUM_W-1] && !ny[NUM_W-1] &&
              (nx < $signed(NUM_W'(wden_s4_ff))) && (ny < $signed(NUM_W'(hden_s4_ff)));
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         nx_s5_ff   <= pt_in ? nx[REM_W-1:0] : '0;
         ny_s5_ff   <= pt_in ? ny[REM_W-1:0] : '0;
         den_s5_ff  <= den_s4_ff;
         in_s5_ff   <= pt_in;
         skip_s5_ff <= skip_s4_ff;
      end
   end

   // ---- floor division, flags ride alongside
   logic [QUO_W-1:0] qx, qy;
   logic             in_d_ff   [QUO_W];
   logic             skip_d_ff [QUO_W];

   mcwcg_div u_div_x (
      .clock (clock),
      .ce    (ce),
      .num   (nx_s5_ff),
      .den   (den_s5_ff),
      .quo   (qx)
   );

   mcwcg_div u_div_y (
      .clock (clock),
      .ce    (ce),
      .num   (ny_s5_ff),
      .den   (den_s5_ff),
      .quo   (qy)
   );

   always_ff @(posedge clock) begin
      if (ce) begin
         in_d_ff[0]   <= in_s5_ff;
         skip_d_ff[0] <= skip_s5_ff;
         for (int i = 1; i < QUO_W; i++) begin
            in_d_ff[i]   <= in_d_ff[i-1];
            skip_d_ff[i] <= skip_d_ff[i-1];
         end
      end
   end

   assign rsp_tvalid = v_ff[PIPE_DEPTH-1];
   assign rsp_tdata  = {(RSP_DATA_W-2*QUO_W-2)'(0), skip_d_ff[QUO_W-1],
                        in_d_ff[QUO_W-1], qy, qx};

`include "mesh_cell_warp_coordinate_generator_top_assert.svh"

   `MCWCG_ASSERT_IMPLY(a_in_not_skipped, clock, reset,
      rsp_tvalid && rsp_tdata[2*QUO_W], !rsp_tdata[2*QUO_W+1])
   `MCWCG_ASSERT_IMPLY(a_outside_zero, clock, reset,
      rsp_tvalid && !rsp_tdata[2*QUO_W], rsp_tdata[2*QUO_W-1:0] == '0)
   `MCWCG_ASSERT_IMPLY(a_x_in_width, clock, reset,
      rsp_tvalid && rsp_tdata[2*QUO_W], DIM_W'(rsp_tdata[QUO_W-1:0]) < w_lim)
   `MCWCG_ASSERT_NEXT(a_hold_on_stall, clock, reset,
      rsp_tvalid && !rsp_tready, rsp_tvalid && !req_tready || rsp_tready)
endmodule
